FILE: hdl/mcdi_pkg.sv
// Shared types, field layout and compare helper for the mesh corner dedup indexer.
`default_nettype none

package mcdi_pkg;

    localparam int SRC_IN_W   = 16;
    localparam int WORD_W     = 32;
    localparam int BONE_W     = 8;
    localparam int OUT_IDX_W  = 12;
    localparam int RED_CNT_W  = 5;

    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 280;
    localparam int OUT_USER_W = 2;

    // input tdata offsets
    localparam int IN_SRC_LO  = 0;
    localparam int IN_PX_LO   = 16;
    localparam int IN_PY_LO   = 48;
    localparam int IN_PZ_LO   = 80;
    localparam int IN_NX_LO   = 112;
    localparam int IN_NY_LO   = 144;
    localparam int IN_NZ_LO   = 176;
    localparam int IN_TS_LO   = 208;
    localparam int IN_TT_LO   = 240;
    localparam int IN_BONE_LO = 272;

    // output tuser bits
    localparam int OU_NEW  = 0;
    localparam int OU_OVER = 1;

    localparam logic [30:0] F32_INF_MAG = 31'h7f80_0000;

    typedef enum logic [1:0] {
        RES_REUSE,
        RES_NEW,
        RES_OVER
    } t_res;

    typedef struct packed {
        logic capture;
        logic red_step;
        logic tab_rd;
        logic rec_rd;
        logic commit;
        t_res kind;
    } t_dp_cmd;

    typedef struct packed {
        logic red_done;
        logic hit;
        logic full;
        logic out_free;
    } t_dp_sts;

    // IEEE single equality on raw patterns
    function automatic logic feq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        a_nan     = a[30:0] > F32_INF_MAG;
        b_nan     = b[30:0] > F32_INF_MAG;
        both_zero = (a[30:0] == '0) && (b[30:0] == '0);
        return !a_nan && !b_nan && (both_zero || (a == b));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mesh_corner_dedup_indexer.sv
// Top level of the mesh corner dedup indexer: sequencer, datapath and checks.
//
// Slave stream takes one triangle corner per beat; master stream returns one
// result beat per corner, in order. Corners are worked one at a time.
// With a power-of-two SRC_VERTICES a corner passes through settling the
// source index, the slot table read and the slot record read and compare,
// and is committed once the result register is free. Any other SRC_VERTICES
// adds the reciprocal-multiply index reduction before the table read.
// Start-of-group in s_tuser zeroes the slot counter; table entries from older
// groups are rejected by a back-pointer check in the slot record, so no
// clearing pass is needed, at reset or per group.
// Reset empties the result register and the slot counter; the block is ready
// in the first cycle after reset. A result waiting on a stalled master side
// does not hold the next corner back until that corner's own result is due.
`default_nettype none

module mesh_corner_dedup_indexer #(
    parameter int SRC_VERTICES = 65536,
    parameter int OUT_SLOTS    = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // src_vertex, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, bone
    input  wire logic [mcdi_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // start_group
    input  wire logic [0:0]                          i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // out_index, vert_x, vert_y, vert_z, vert_nx, vert_ny, vert_nz, vert_s, vert_t,
    // vert_bone, zero pad
    output logic      [mcdi_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // is_new, overflow
    output logic      [mcdi_pkg::OUT_USER_W-1:0]     o_m_tuser
);

    import mcdi_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mcdi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mcdi_dp #(
        .SRC_VERTICES (SRC_VERTICES),
        .OUT_SLOTS    (OUT_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser[0]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

`ifndef ASSERT_OFF
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while previous corner in flight");

    a_no_commit_when_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_cmd.commit)
        else $error("result committed with no corner in flight");

    a_flags_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[OU_NEW] && o_m_tuser[OU_OVER]))
        else $error("result both new and overflow");

    a_reuse_no_record : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[OU_NEW]) |-> (o_m_tdata[OUT_DATA_W-1:OUT_IDX_W] == '0))
        else $error("vertex record on a beat without a new slot");
`endif

endmodule

`default_nettype wire

FILE: hdl/mcdi_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mcdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/mcdi_ctrl.sv
// Sequencer for one corner at a time: capture, index reduce, table read, record read, commit.
`default_nettype none

module mcdi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire mcdi_pkg::t_dp_sts i_sts,
    output mcdi_pkg::t_dp_cmd      o_cmd
);

    import mcdi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RED,
        ST_TAB,
        ST_REC
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_RED;
                        r_ready <= 1'b0;
                    end
                end
                ST_RED: begin
                    if (i_sts.red_done) begin
                        r_state <= ST_TAB;
                    end
                end
                ST_TAB: begin
                    r_state <= ST_REC;
                end
                ST_REC: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd = '{capture: 1'b0, red_step: 1'b0, tab_rd: 1'b0, rec_rd: 1'b0,
                  commit: 1'b0, kind: RES_REUSE};
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = r_ready && i_s_tvalid;
            end
            ST_RED: begin
                o_cmd.red_step = !i_sts.red_done;
                o_cmd.tab_rd   = i_sts.red_done;
            end
            ST_TAB: begin
                o_cmd.rec_rd = 1'b1;
            end
            ST_REC: begin
                o_cmd.commit = i_sts.out_free;
                // unknown hit (never-written entry) falls to a fresh slot, or to overflow when full
                if (i_sts.hit) begin
                    o_cmd.kind = RES_REUSE;
                end else if (i_sts.full) begin
                    o_cmd.kind = RES_OVER;
                end else begin
                    o_cmd.kind = RES_NEW;
                end
            end
            default: begin
                o_cmd.capture = 1'b0;
            end
        endcase
    end

    assign o_s_tready = r_ready;

endmodule

`default_nettype wire

FILE: hdl/mcdi_dp.sv
// Datapath: input capture, source index reduction, slot table, slot records, result register.
`default_nettype none

module mcdi_dp #(
    parameter int SRC_VERTICES = 65536,
    parameter int OUT_SLOTS    = 4096
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mcdi_pkg::t_dp_cmd                   i_cmd,
    output mcdi_pkg::t_dp_sts                        o_sts,
    input  wire logic [mcdi_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  wire logic                                i_s_tuser,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic      [mcdi_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic      [mcdi_pkg::OUT_USER_W-1:0]     o_m_tuser
);

    import mcdi_pkg::*;

    localparam int SRC_W    = $clog2(SRC_VERTICES);
    localparam int SLOT_W   = $clog2(OUT_SLOTS);
    localparam int CNT_W    = $clog2(OUT_SLOTS + 1);
    localparam int EXT_W    = (SLOT_W > OUT_IDX_W) ? SLOT_W : OUT_IDX_W;
    localparam int REC_W    = SRC_W + 5 * WORD_W;
    localparam bit SRC_POW2 = (SRC_VERTICES == (1 << SRC_W));

    logic [IN_DATA_W-1:0]  r_din;
    logic [CNT_W-1:0]      r_next;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [OUT_USER_W-1:0] n_out_user;

    logic [SRC_W-1:0]  w_src_idx;
    logic              w_red_done;
    logic [SLOT_W-1:0] w_tab_slot;
    logic [REC_W-1:0]  w_rec;
    logic [REC_W-1:0]  w_rec_wdata;
    logic              w_wr_new;
    logic              w_in_range;
    logic [SLOT_W-1:0] w_idx_slot;
    logic [EXT_W-1:0]  w_idx_ext;

    logic [WORD_W-1:0] w_nx, w_ny, w_nz, w_ts, w_tt;

    assign w_nx = r_din[IN_NX_LO +: WORD_W];
    assign w_ny = r_din[IN_NY_LO +: WORD_W];
    assign w_nz = r_din[IN_NZ_LO +: WORD_W];
    assign w_ts = r_din[IN_TS_LO +: WORD_W];
    assign w_tt = r_din[IN_TT_LO +: WORD_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_din <= i_s_tdata;
        end
    end

    // source index modulo table depth
    generate
        if (SRC_POW2) begin : g_red_mask
            logic [SRC_W-1:0] r_src_idx;
            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_src_idx <= i_s_tdata[IN_SRC_LO +: SRC_W];
                end
            end
            assign w_src_idx  = r_src_idx;
            assign w_red_done = 1'b1;
        end else begin : g_red_recip
            // quotient by reciprocal, exact for 16-bit indices with k = 16 + ceil(log2 N)
            localparam int                RCP_SH = SRC_IN_W + SRC_W;
            localparam logic [SRC_IN_W:0] RCP_M  = (SRC_IN_W + 1)'(
                ((64'd1 << RCP_SH) + 64'(SRC_VERTICES) - 64'd1) / 64'(SRC_VERTICES));
            localparam logic [SRC_IN_W:0] DIV_C  = (SRC_IN_W + 1)'(SRC_VERTICES);
            logic [SRC_IN_W-1:0]  r_num;
            logic [SRC_IN_W-1:0]  r_quo;
            logic [SRC_W-1:0]     r_rem;
            logic [RED_CNT_W-1:0] r_cnt;
            logic [2*SRC_IN_W:0]  w_prod;
            logic [2*SRC_IN_W:0]  w_back;
            assign w_prod = {{(SRC_IN_W + 1){1'b0}}, r_num} * {{SRC_IN_W{1'b0}}, RCP_M};
            assign w_back = {{(SRC_IN_W + 1){1'b0}}, r_quo} * {{SRC_IN_W{1'b0}}, DIV_C};
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cnt <= '0;
                end else if (i_cmd.capture) begin
                    r_cnt <= '0;
                end else if (i_cmd.red_step) begin
                    r_cnt <= r_cnt + RED_CNT_W'(1);
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_num <= i_s_tdata[IN_SRC_LO +: SRC_IN_W];
                end
                if (i_cmd.red_step && (r_cnt == RED_CNT_W'(0))) begin
                    r_quo <= SRC_IN_W'(w_prod >> RCP_SH);
                end
                if (i_cmd.red_step && (r_cnt == RED_CNT_W'(1))) begin
                    r_rem <= SRC_W'(r_num - w_back[SRC_IN_W-1:0]);
                end
            end
            assign w_src_idx  = r_rem;
            assign w_red_done = (r_cnt == RED_CNT_W'(2));
        end
    endgenerate

    assign w_wr_new = i_cmd.commit && (i_cmd.kind == RES_NEW);

    mcdi_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SRC_VERTICES)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (w_wr_new),
        .i_waddr (w_src_idx),
        .i_wdata (r_next[SLOT_W-1:0]),
        .i_re    (i_cmd.tab_rd),
        .i_raddr (w_src_idx),
        .o_rdata (w_tab_slot)
    );

    // record: owning source, nz, ny, nx, t, s
    assign w_rec_wdata = {w_src_idx, w_nz, w_ny, w_nx, w_tt, w_ts};

    mcdi_ram #(
        .WIDTH (REC_W),
        .DEPTH (OUT_SLOTS)
    ) u_rec (
        .i_clk   (i_clk),
        .i_we    (w_wr_new),
        .i_waddr (r_next[SLOT_W-1:0]),
        .i_wdata (w_rec_wdata),
        .i_re    (i_cmd.rec_rd),
        .i_raddr (w_tab_slot),
        .o_rdata (w_rec)
    );

    // a table entry is live only if its slot is in use this group and points back here
    assign w_in_range = CNT_W'(w_tab_slot) < r_next;

    assign o_sts.red_done = w_red_done;
    assign o_sts.hit      = w_in_range
                         && (w_rec[5*WORD_W +: SRC_W] == w_src_idx)
                         && feq(w_ts, w_rec[0 +: WORD_W])
                         && feq(w_tt, w_rec[WORD_W +: WORD_W])
                         && feq(w_nx, w_rec[2*WORD_W +: WORD_W])
                         && feq(w_ny, w_rec[3*WORD_W +: WORD_W])
                         && feq(w_nz, w_rec[4*WORD_W +: WORD_W]);
    assign o_sts.full     = (r_next == CNT_W'(OUT_SLOTS));
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else if (i_cmd.capture && i_s_tuser) begin
            r_next <= '0;
        end else if (w_wr_new) begin
            r_next <= r_next + CNT_W'(1);
        end
    end

    assign w_idx_slot = (i_cmd.kind == RES_NEW) ? r_next[SLOT_W-1:0] : w_tab_slot;
    assign w_idx_ext  = EXT_W'(w_idx_slot);

    always_comb begin
        n_out_data = '0;
        n_out_user = '0;
        case (i_cmd.kind)
            RES_NEW: begin
                n_out_data[OUT_IDX_W-1:0] = w_idx_ext[OUT_IDX_W-1:0];
                n_out_data[OUT_IDX_W +: 8*WORD_W + BONE_W] =
                    r_din[IN_PX_LO +: 8*WORD_W + BONE_W];
                n_out_user[OU_NEW] = 1'b1;
            end
            RES_REUSE: begin
                n_out_data[OUT_IDX_W-1:0] = w_idx_ext[OUT_IDX_W-1:0];
            end
            RES_OVER: begin
                n_out_user[OU_OVER] = 1'b1;
            end
            default: begin
                n_out_user = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire
